// ===== design/tfdx_pkg.sv =====
package tfdx_pkg;

	localparam logic [7:0] START_BYTE = 8'hAA;
	localparam logic [7:0] END_BYTE   = 8'hBB;

	localparam logic [3:0] POS_IDLE      = 4'd0;
	localparam logic [3:0] POS_FIRST     = 4'd1;
	localparam logic [3:0] POS_CC_HI     = 4'd4;
	localparam logic [3:0] POS_CC_LO     = 4'd5;
	localparam logic [3:0] POS_ID_FIRST  = 4'd6;
	localparam logic [3:0] POS_DATA_LAST = 4'd10;
	localparam logic [3:0] POS_CHECK     = 4'd11;
	localparam logic [3:0] POS_END       = 4'd12;

	typedef logic [3:0] pos_t;

	typedef struct packed {
		logic [15:0] country_code;
		logic [39:0] tag_id;
	} result_t;

endpackage

// ===== design/tfdx_rx_if.sv =====
interface tfdx_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/tfdx_tag_if.sv =====
interface tfdx_tag_if;
	logic        valid;
	logic        ready;
	logic [15:0] country_code;
	logic [39:0] tag_id;

	modport source (output valid, output country_code, output tag_id, input ready);
	modport sink (input valid, input country_code, input tag_id, output ready);
endinterface

// ===== design/tag_frame_deframer_xor_check_core.sv =====
// the end byte of a good frame is registered at intake; once processed, its result is registered in the output stage
// throughput: one byte per cycle while the result side keeps up
// a held result stalls byte intake only until it is taken
// reset (arst_n low, asynchronous) returns to idle waiting for a start byte, clears captures
// and drops any byte or result in flight
module tag_frame_deframer_xor_check_core (
	input logic       clk,
	input logic       arst_n,
	tfdx_rx_if.sink   rx,
	tfdx_tag_if.source tag
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_free;
	logic              process;
	logic              hit;
	tfdx_pkg::result_t res;
	tfdx_pkg::result_t res_q;
	tfdx_pkg::pos_t    pos;

	assign out_free = !tag.valid || tag.ready;
	assign process  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	tfdx_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (process),
		.rx_byte (byte_s1),
		.hit     (hit),
		.res     (res),
		.pos     (pos)
	);

	tfdx_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (process),
		.hit    (hit),
		.res    (res),
		.ready  (tag.ready),
		.valid  (tag.valid),
		.res_q  (res_q)
	);

	assign tag.country_code = res_q.country_code;
	assign tag.tag_id       = res_q.tag_id;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos <= tfdx_pkg::POS_END)
		else $error("frame position out of range");

	a_hit_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (pos == tfdx_pkg::POS_END) && process)
		else $error("result outside end byte");

	a_rose_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tag.valid) |-> $past(process))
		else $error("result without a processed byte");

	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !process |=> valid_s1 && $stable(byte_s1))
		else $error("stalled item lost");

endmodule

// ===== design/tfdx_parse.sv =====
module tfdx_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	output logic              hit,
	output tfdx_pkg::result_t res,
	output tfdx_pkg::pos_t    pos
);

	tfdx_pkg::pos_t pos_q;
	logic [7:0]     xor_q;
	logic [7:0]     chk_q;
	logic [15:0]    cc_q;
	logic [39:0]    id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= tfdx_pkg::POS_IDLE;
			xor_q <= '0;
			chk_q <= '0;
			cc_q  <= '0;
			id_q  <= '0;
		end else if (en) begin
			case (pos_q)
				tfdx_pkg::POS_IDLE: begin
					if (rx_byte == tfdx_pkg::START_BYTE) begin
						xor_q <= '0;
						pos_q <= tfdx_pkg::POS_FIRST;
					end
				end
				tfdx_pkg::POS_CHECK: begin
					chk_q <= rx_byte;
					pos_q <= tfdx_pkg::POS_END;
				end
				tfdx_pkg::POS_END: begin
					pos_q <= tfdx_pkg::POS_IDLE;
				end
				default: begin
					if (pos_q <= tfdx_pkg::POS_DATA_LAST) begin
						xor_q <= xor_q ^ rx_byte;
						if (pos_q == tfdx_pkg::POS_CC_HI || pos_q == tfdx_pkg::POS_CC_LO) begin
							cc_q <= {cc_q[7:0], rx_byte};
						end else if (pos_q >= tfdx_pkg::POS_ID_FIRST) begin
							id_q <= {id_q[31:0], rx_byte};
						end
						pos_q <= pos_q + 4'd1;
					end else begin
						pos_q <= tfdx_pkg::POS_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		hit = en && (pos_q == tfdx_pkg::POS_END) && (rx_byte == tfdx_pkg::END_BYTE)
			&& (xor_q == chk_q);
		res.country_code = cc_q;
		res.tag_id       = id_q;
	end

	assign pos = pos_q;

endmodule

// ===== design/tfdx_out_reg.sv =====
module tfdx_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              hit,
	input  tfdx_pkg::result_t res,
	input  logic              ready,
	output logic              valid,
	output tfdx_pkg::result_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= hit || (valid_q && !ready);
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && hit) begin
			res_q <= res;
		end
	end

	assign valid = valid_q;

endmodule
